// File: design/buddy_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy page allocator: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication on the rising edge of clk, idle in reset.
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the rising edge of clk, idle in reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Pool geometry, bitmap layout helpers, status and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int TOP_LEVEL  = 10;
    localparam int BITS_SIZE  = 2 * POOL_PAGES;
    localparam int BM_WORDS   = BITS_SIZE / 32;

    localparam logic [3:0] TAG_NONE = 4'hF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_TOO_LARGE = 3'd1,
        STAT_OVER_CAP  = 3'd2,
        STAT_NO_BLOCK  = 3'd3,
        STAT_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_A_SCAN,
        S_RD,
        S_WR,
        S_A_FIN,
        S_F_RD,
        S_F_CHK
    } state_t;

    function automatic logic [10:0] lvl_base(input logic [3:0] lv);
        logic [11:0] t;
        t = 12'(BITS_SIZE) - (12'(BITS_SIZE) >> lv);
        return t[10:0];
    endfunction

    function automatic logic [31:0] lvl_mask(input logic [3:0] lv);
        logic [10:0] b;
        logic [63:0] m;
        logic [11:0] blocks;
        b = lvl_base(lv);
        blocks = 12'(POOL_PAGES) >> lv;
        if (blocks >= 12'd32)
        begin
            m = {64{1'b1}};
        end
        else
        begin
            m = ((64'd1 << blocks) - 64'd1) << b[4:0];
        end
        return m[31:0];
    endfunction

endpackage

`default_nettype wire

// File: design/bpa_ffs.sv
// ----------------------------------------------------------------------------
// Buddy page allocator: lowest set bit
// Returns the index of the lowest set bit of a bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ffs
(
    input  wire logic [31:0] vec,
    output logic      [4:0]  idx
);

    always_comb
    begin
        idx = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = 5'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy allocator over 1024 pages with per-level free bitmaps.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------
//  request  | start / busy   | cmd, alloc_pages, free_page
//  result   | done (1 cycle) | status, page_index, block_level, used_pages
//
//  Reset starts a clearing pass of both memories; busy stays high.
//  Allocate: a check, a scan of the bitmap words at the chosen level, a
//  read and a write per bitmap level written, a tag write, then the done strobe.
//  Free: a tag read and check, a read and a write per bitmap level, then done.
//  Rejected requests end after their check. Every bitmap update is a read then
//  a write of one 32-bit word; the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [10:0] alloc_pages,
    input  wire logic [9:0]  free_page,
    output logic             done,
    output logic [2:0]       status,
    output logic [9:0]       page_index,
    output logic [3:0]       block_level,
    output logic [10:0]      used_pages
);

    bpa_pkg::state_t state_reg, state_next;

    logic [31:0] bm_mem [0:bpa_pkg::BM_WORDS-1];
    logic [3:0]  tag_mem [0:bpa_pkg::POOL_PAGES-1];
    logic [31:0] bm_rdata_reg;
    logic [3:0]  tag_rdata_reg;
    logic [5:0]  bm_addr;
    logic        bm_we;
    logic [31:0] bm_wdata;
    logic [9:0]  tag_addr;
    logic        tag_we;
    logic [3:0]  tag_wdata;

    logic [10:0] cnt_reg [0:bpa_pkg::TOP_LEVEL];
    logic        cnt_we;
    logic [10:0] cnt_next;

    logic [9:0]  clr_reg, clr_next;
    logic        cmd_reg, cmd_next;
    logic [10:0] n_reg, n_next;
    logic [9:0]  p_reg, p_next;
    logic [3:0]  need_reg, need_next;
    logic [3:0]  lv_reg, lv_next;
    logic [9:0]  off_reg, off_next;
    logic        split_reg, split_next;
    logic [5:0]  scan_reg, scan_next;
    logic        first_reg, first_next;
    logic [10:0] used_reg, used_next;
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic [9:0]  page_reg, page_next;
    logic [3:0]  level_reg, level_next;

    logic [10:0] n_eff;
    logic [3:0]  need_c;
    logic        fit_c;
    logic [3:0]  sel_c;
    logic        sel_ok;
    logic [10:0] sel_base;
    logic [31:0] hit_word;
    logic [4:0]  hit_bit;
    logic [5:0]  hit_wa;
    logic [10:0] hit_pos;
    logic [10:0] cur_pos;
    logic [4:0]  bit_a;
    logic [4:0]  bit_b;
    logic        old_a, old_b, new_a, new_b;
    logic [31:0] wword;
    logic        bud_set;
    logic [10:0] lv_size;

    bpa_ffs u_ffs
    (
        .vec (hit_word),
        .idx (hit_bit)
    );

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_addr] <= bm_wdata;
        end
        bm_rdata_reg <= bm_mem[bm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_addr] <= tag_wdata;
        end
        tag_rdata_reg <= tag_mem[tag_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= bpa_pkg::TOP_LEVEL; i++)
            begin
                cnt_reg[i] <= (i == bpa_pkg::TOP_LEVEL) ? 11'd1 : 11'd0;
            end
        end
        else if (cnt_we)
        begin
            cnt_reg[lv_reg] <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_CLEAR;
            clr_reg   <= 10'd0;
            used_reg  <= 11'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        need_reg   <= need_next;
        lv_reg     <= lv_next;
        off_reg    <= off_next;
        split_reg  <= split_next;
        scan_reg   <= scan_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        level_reg  <= level_next;
    end

    always_comb
    begin
        n_eff  = (n_reg == 11'd0) ? 11'd1 : n_reg;
        fit_c  = (n_eff <= 11'(bpa_pkg::POOL_PAGES));
        need_c = 4'd0;
        for (int k = bpa_pkg::TOP_LEVEL; k >= 0; k--)
        begin
            if ((12'd1 << k) >= {1'b0, n_eff})
            begin
                need_c = 4'(k);
            end
        end
        sel_c  = 4'd0;
        sel_ok = 1'b0;
        for (int k = bpa_pkg::TOP_LEVEL; k >= 0; k--)
        begin
            if ((4'(k) >= need_c) && (cnt_reg[k] != 11'd0))
            begin
                sel_c  = 4'(k);
                sel_ok = 1'b1;
            end
        end
        sel_base = bpa_pkg::lvl_base(sel_c);
    end

    always_comb
    begin
        hit_word = bm_rdata_reg & bpa_pkg::lvl_mask(lv_reg);
        hit_wa   = scan_reg - 6'd1;
        hit_pos  = {hit_wa, hit_bit};
        cur_pos  = bpa_pkg::lvl_base(lv_reg) + {1'b0, off_reg};
        bit_a    = cur_pos[4:0];
        bit_b    = bit_a ^ 5'd1;
        old_a    = bm_rdata_reg[bit_a];
        old_b    = bm_rdata_reg[bit_b];
        bud_set  = (lv_reg < 4'(bpa_pkg::TOP_LEVEL)) && old_b;
        lv_size  = 11'd1 << lv_reg;
        if (cmd_reg == bpa_pkg::CMD_ALLOC)
        begin
            new_a = 1'b0;
            new_b = split_reg ? 1'b1 : old_b;
        end
        else if (bud_set)
        begin
            new_a = 1'b0;
            new_b = 1'b0;
        end
        else
        begin
            new_a = 1'b1;
            new_b = old_b;
        end
        wword        = bm_rdata_reg;
        wword[bit_a] = new_a;
        wword[bit_b] = new_b;
        cnt_next = cnt_reg[lv_reg] + 11'(new_a) + 11'(new_b)
                   - 11'(old_a) - 11'(old_b);
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        need_next   = need_reg;
        lv_next     = lv_reg;
        off_next    = off_reg;
        split_next  = split_reg;
        scan_next   = scan_reg;
        first_next  = first_reg;
        used_next   = used_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        page_next   = page_reg;
        level_next  = level_reg;
        bm_addr     = cur_pos[10:5];
        bm_we       = 1'b0;
        bm_wdata    = wword;
        tag_addr    = p_reg;
        tag_we      = 1'b0;
        tag_wdata   = bpa_pkg::TAG_NONE;
        cnt_we      = 1'b0;

        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                tag_addr  = clr_reg;
                tag_we    = 1'b1;
                bm_addr   = clr_reg[5:0];
                bm_we     = (clr_reg < 10'(bpa_pkg::BM_WORDS));
                bm_wdata  = (clr_reg == 10'(bpa_pkg::BM_WORDS - 1)) ?
                            bpa_pkg::lvl_mask(4'(bpa_pkg::TOP_LEVEL)) : 32'd0;
                clr_next = clr_reg + 10'd1;
                if (clr_reg == 10'(bpa_pkg::POOL_PAGES - 1))
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    n_next     = alloc_pages;
                    p_next     = free_page;
                    state_next = (cmd == bpa_pkg::CMD_FREE) ?
                                 bpa_pkg::S_F_RD : bpa_pkg::S_A_CHK;
                end
            end
            bpa_pkg::S_A_CHK:
            begin
                need_next  = need_c;
                page_next  = 10'd0;
                level_next = 4'd0;
                if (!fit_c)
                begin
                    status_next = bpa_pkg::STAT_TOO_LARGE;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::S_IDLE;
                end
                else
                begin
                    need_next  = need_c;
                    state_next = bpa_pkg::S_A_SCAN;
                end
            end
            bpa_pkg::S_A_SCAN:
            begin
                bm_addr    = scan_reg;
                first_next = 1'b0;
                scan_next  = scan_reg + 6'd1;
                if (!first_reg && (hit_word != 32'd0))
                begin
                    off_next   = 10'(hit_pos - bpa_pkg::lvl_base(lv_reg));
                    split_next = 1'b0;
                    state_next = bpa_pkg::S_RD;
                end
            end
            bpa_pkg::S_RD:
            begin
                state_next = bpa_pkg::S_WR;
            end
            bpa_pkg::S_WR:
            begin
                bm_we  = 1'b1;
                cnt_we = 1'b1;
                if (cmd_reg == bpa_pkg::CMD_ALLOC)
                begin
                    if (lv_reg > need_reg)
                    begin
                        lv_next    = lv_reg - 4'd1;
                        off_next   = {off_reg[8:0], 1'b0};
                        split_next = 1'b1;
                        state_next = bpa_pkg::S_RD;
                    end
                    else
                    begin
                        state_next = bpa_pkg::S_A_FIN;
                    end
                end
                else if (bud_set)
                begin
                    lv_next    = lv_reg + 4'd1;
                    off_next   = off_reg >> 1;
                    state_next = bpa_pkg::S_RD;
                end
                else
                begin
                    used_next   = (used_reg >= (11'd1 << level_reg)) ?
                                  used_reg - (11'd1 << level_reg) : 11'd0;
                    status_next = bpa_pkg::STAT_OK;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_A_FIN:
            begin
                tag_addr    = 10'(off_reg << need_reg);
                tag_wdata   = need_reg;
                tag_we      = 1'b1;
                used_next   = used_reg + lv_size;
                status_next = bpa_pkg::STAT_OK;
                page_next   = 10'(off_reg << need_reg);
                level_next  = need_reg;
                done_next   = 1'b1;
                state_next  = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_F_RD:
            begin
                state_next = bpa_pkg::S_F_CHK;
            end
            bpa_pkg::S_F_CHK:
            begin
                page_next  = 10'd0;
                level_next = 4'd0;
                if ((tag_rdata_reg == bpa_pkg::TAG_NONE) ||
                    (tag_rdata_reg > 4'(bpa_pkg::TOP_LEVEL)))
                begin
                    status_next = bpa_pkg::STAT_NOT_ALLOC;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::S_IDLE;
                end
                else
                begin
                    tag_we     = 1'b1;
                    lv_next    = tag_rdata_reg;
                    level_next = tag_rdata_reg;
                    off_next   = p_reg >> tag_rdata_reg;
                    state_next = bpa_pkg::S_RD;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase

        if (state_reg == bpa_pkg::S_A_CHK && fit_c)
        begin
            if ({1'b0, used_reg} + (12'd1 << need_c) > 12'(bpa_pkg::POOL_PAGES))
            begin
                status_next = bpa_pkg::STAT_OVER_CAP;
                done_next   = 1'b1;
                state_next  = bpa_pkg::S_IDLE;
            end
            else if (!sel_ok)
            begin
                status_next = bpa_pkg::STAT_NO_BLOCK;
                done_next   = 1'b1;
                state_next  = bpa_pkg::S_IDLE;
            end
            else
            begin
                lv_next    = sel_c;
                scan_next  = sel_base[10:5];
                first_next = 1'b1;
            end
        end
    end

    assign busy        = (state_reg != bpa_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign page_index  = page_reg;
    assign block_level = level_reg;
    assign used_pages  = used_reg;

endmodule

`default_nettype wire

// File: design/bpa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_page_allocator_defines.svh"

module bpa_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [9:0]  page_index,
    input  wire logic [3:0]  block_level,
    input  wire logic [10:0] used_pages
);

    `BPA_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
    `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done,
                     "accepted transaction not held")
    `BPA_ASSERT_SAME(a_fail_page, done && (status != bpa_pkg::STAT_OK),
                     page_index == 10'd0 && block_level == 4'd0,
                     "failed transaction with page or level")
    `BPA_ASSERT_SAME(a_used_range, done, used_pages <= 11'(bpa_pkg::POOL_PAGES),
                     "pages in use beyond pool")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .page_index  (page_index),
    .block_level (block_level),
    .used_pages  (used_pages)
);

`default_nettype wire

// File: tb/tb_buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free transactions through start/busy, predicts each
// result with a behavioural buddy model held in local arrays, and compares
// every done strobe field by field against the oldest prediction. A short
// stimulus table covers the edge cases, then mixed random traffic follows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_buddy_page_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  page_index;
        logic [3:0]  block_level;
        logic [10:0] used_pages;
    } alloc_result_t;

    typedef struct {
        logic             cmd;
        logic [10:0]      alloc_pages;
        logic [9:0]       free_page;
        logic             has_exp;
        bpa_pkg::status_t exp_status;
        logic [3:0]       exp_level;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [10:0] alloc_pages;
    logic [9:0]  free_page;
    logic        done;
    logic [2:0]  status;
    logic [9:0]  page_index;
    logic [3:0]  block_level;
    logic [10:0] used_pages;

    buddy_page_allocator dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .alloc_pages (alloc_pages),
        .free_page   (free_page),
        .done        (done),
        .status      (status),
        .page_index  (page_index),
        .block_level (block_level),
        .used_pages  (used_pages)
    );

    logic          blk_free [0:bpa_pkg::TOP_LEVEL][0:bpa_pkg::POOL_PAGES-1];
    logic [3:0]    tag_of [0:bpa_pkg::POOL_PAGES-1];
    int unsigned   pages_used;
    alloc_result_t pending_results[$];
    int            held_pages[$];
    int            errors;
    int            mismatches;
    longint        cycles;
    int            idle_pct;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void buddy_reset();
        for (int l = 0; l <= bpa_pkg::TOP_LEVEL; l++)
        begin
            for (int i = 0; i < bpa_pkg::POOL_PAGES; i++)
            begin
                blk_free[l][i] = 1'b0;
            end
        end
        blk_free[bpa_pkg::TOP_LEVEL][0] = 1'b1;
        for (int i = 0; i < bpa_pkg::POOL_PAGES; i++)
        begin
            tag_of[i] = bpa_pkg::TAG_NONE;
        end
        pages_used = 0;
    endfunction

    function automatic alloc_result_t buddy_apply(logic c, logic [10:0] n_in,
                                                  logic [9:0] p);
        alloc_result_t r;
        int            n;
        int            need;
        int            lv;
        int            off;
        bit            found;
        r = '0;
        r.status = bpa_pkg::STAT_OK;
        if (c == bpa_pkg::CMD_ALLOC)
        begin
            n = (n_in == 0) ? 1 : n_in;
            need = 0;
            while (need <= bpa_pkg::TOP_LEVEL && (1 << need) < n)
            begin
                need++;
            end
            if (need > bpa_pkg::TOP_LEVEL)
            begin
                r.status = bpa_pkg::STAT_TOO_LARGE;
            end
            else if (pages_used + (1 << need) > bpa_pkg::POOL_PAGES)
            begin
                r.status = bpa_pkg::STAT_OVER_CAP;
            end
            else
            begin
                found = 0;
                off = 0;
                for (lv = need; lv <= bpa_pkg::TOP_LEVEL && !found; lv++)
                begin
                    for (int i = 0; i < (bpa_pkg::POOL_PAGES >> lv) && !found; i++)
                    begin
                        if (blk_free[lv][i])
                        begin
                            off = i;
                            found = 1;
                        end
                    end
                    if (found)
                    begin
                        break;
                    end
                end
                if (!found)
                begin
                    r.status = bpa_pkg::STAT_NO_BLOCK;
                end
                else
                begin
                    blk_free[lv][off] = 1'b0;
                    while (lv > need)
                    begin
                        lv--;
                        off = off * 2;
                        blk_free[lv][off] = 1'b0;
                        blk_free[lv][off+1] = 1'b1;
                    end
                    r.page_index = 10'(off << need);
                    tag_of[off << need] = 4'(need);
                    pages_used += 1 << need;
                    r.block_level = 4'(need);
                    held_pages.push_back(off << need);
                end
            end
        end
        else
        begin
            if (tag_of[p] == bpa_pkg::TAG_NONE || tag_of[p] > bpa_pkg::TOP_LEVEL)
            begin
                r.status = bpa_pkg::STAT_NOT_ALLOC;
            end
            else
            begin
                lv = tag_of[p];
                off = p >> lv;
                tag_of[p] = bpa_pkg::TAG_NONE;
                for (int i = lv; i <= bpa_pkg::TOP_LEVEL; i++)
                begin
                    blk_free[i][off] = 1'b1;
                    if (i == bpa_pkg::TOP_LEVEL || !blk_free[i][off ^ 1])
                    begin
                        break;
                    end
                    blk_free[i][off ^ 1] = 1'b0;
                    blk_free[i][off] = 1'b0;
                    off = off >> 1;
                end
                pages_used = (pages_used >= (1 << lv)) ? pages_used - (1 << lv) : 0;
                r.block_level = 4'(lv);
                for (int k = 0; k < held_pages.size(); k++)
                begin
                    if (held_pages[k] == p)
                    begin
                        held_pages.delete(k);
                        break;
                    end
                end
            end
        end
        r.used_pages = 11'(pages_used);
        return r;
    endfunction

    task automatic issue(logic c, logic [10:0] n, logic [9:0] p, logic has_exp,
                         bpa_pkg::status_t es, logic [3:0] el);
        alloc_result_t r;
        @(posedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        alloc_pages <= n;
        free_page <= p;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        r = buddy_apply(c, n, p);
        if (has_exp && (r.status != es || r.block_level != el))
        begin
            $display("table row disagrees with model: cmd %0d n %0d p %0d", c, n, p);
            errors++;
        end
        pending_results.push_back(r);
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result status %0d", status);
                end
            end
            else
            begin
                e = pending_results.pop_front();
                if (e != {status, page_index, block_level, used_pages})
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"mismatch exp st %0d pg %0d lv %0d used %0d",
                                  " got %0d %0d %0d %0d"},
                                 e.status, e.page_index, e.block_level, e.used_pages,
                                 status, page_index, block_level, used_pages);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    stim_row_t stim_table[$];

    task automatic add_row(logic c, logic [10:0] n, logic [9:0] p, logic h,
                           bpa_pkg::status_t s, logic [3:0] l);
        stim_table.push_back('{c, n, p, h, s, l});
    endtask

    initial
    begin
        int kind;
        int n;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        idle_pct = 24;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = bpa_pkg::CMD_ALLOC;
        alloc_pages = '0;
        free_page = '0;
        buddy_reset();

        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd0, 1, bpa_pkg::STAT_NOT_ALLOC, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd1025, 10'd0, 1, bpa_pkg::STAT_TOO_LARGE, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'h7FF, 10'd0, 1, bpa_pkg::STAT_TOO_LARGE, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd0, 10'd0, 1, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd1024, 10'd0, 1, bpa_pkg::STAT_OVER_CAP, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd3, 10'd0, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd512, 10'd0, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd4, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd5, 1, bpa_pkg::STAT_NOT_ALLOC, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd1023, 1, bpa_pkg::STAT_NOT_ALLOC, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd256, 10'd0, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd256, 10'd0, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd0, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd0, 1, bpa_pkg::STAT_NOT_ALLOC, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd512, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd256, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd768, 0, bpa_pkg::STAT_OK, 4'd0);
        add_row(bpa_pkg::CMD_ALLOC, 11'd1024, 10'd0, 1, bpa_pkg::STAT_OK, 4'd10);
        add_row(bpa_pkg::CMD_ALLOC, 11'd1, 10'd0, 1, bpa_pkg::STAT_OVER_CAP, 4'd0);
        add_row(bpa_pkg::CMD_FREE, 11'd0, 10'd0, 1, bpa_pkg::STAT_OK, 4'd10);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            issue(stim_table[i].cmd, stim_table[i].alloc_pages, stim_table[i].free_page,
                  stim_table[i].has_exp, stim_table[i].exp_status, stim_table[i].exp_level);
        end

        for (int t = 0; t < 1600; t++)
        begin
            idle_pct = (t >= 400 && t < 600) ? 0 : 24;
            if (t == 800)
            begin
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                case ($urandom_range(9))
                    0: n = $urandom_range(2047);
                    1: n = $urandom_range(1024, 128);
                    default: n = $urandom_range(16);
                endcase
                issue(bpa_pkg::CMD_ALLOC, 11'(n), 10'($urandom), 0, bpa_pkg::STAT_OK, 4'd0);
            end
            else if (kind < 85 && held_pages.size() != 0)
            begin
                issue(bpa_pkg::CMD_FREE, 11'($urandom),
                      10'(held_pages[$urandom_range(held_pages.size() - 1)]),
                      0, bpa_pkg::STAT_OK, 4'd0);
            end
            else
            begin
                issue(bpa_pkg::CMD_FREE, 11'($urandom), 10'($urandom), 0,
                      bpa_pkg::STAT_OK, 4'd0);
            end
        end

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
